@@ hdl/apt_pkg.sv @@
// ----------------------------------------------------------------------------
// Affine point transform package
// Shared widths, types, register indexes and arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package apt_pkg;

    localparam int CoordWidth = 32;
    localparam int CoefWidth  = 16;
    localparam int CoefFrac   = 12;
    localparam int NumAxes    = 3;
    localparam int LinWidth   = CoefWidth * NumAxes;
    localparam int ProdWidth  = CoordWidth + CoefWidth;
    localparam int RndWidth   = ProdWidth - CoefFrac;
    localparam int SumWidth   = RndWidth + 2;
    localparam int CfgIdxW    = 3;

    typedef logic signed [CoordWidth-1:0] coord_t;
    typedef logic signed [CoefWidth-1:0]  coef_t;
    typedef logic signed [ProdWidth-1:0]  prod_t;
    typedef logic signed [RndWidth-1:0]   rnd_t;
    typedef logic signed [SumWidth-1:0]   sum_t;
    typedef logic [LinWidth-1:0]          lin_t;
    typedef logic [CfgIdxW-1:0]           cfg_idx_t;

    localparam cfg_idx_t RegRow0Linear = 3'd0;
    localparam cfg_idx_t RegRow1Linear = 3'd1;
    localparam cfg_idx_t RegRow2Linear = 3'd2;
    localparam cfg_idx_t RegRow0Offset = 3'd3;
    localparam cfg_idx_t RegRow1Offset = 3'd4;
    localparam cfg_idx_t RegRow2Offset = 3'd5;

    localparam lin_t   Row0LinearReset = 48'h0000_0000_1000;
    localparam lin_t   Row1LinearReset = 48'h0000_1000_0000;
    localparam lin_t   Row2LinearReset = 48'h1000_0000_0000;

    localparam coord_t CoordMax = 32'sh7FFF_FFFF;
    localparam coord_t CoordMin = 32'sh8000_0000;

    // Round a Q28.20 product to Q28.8, nearest with ties towards plus infinity.
    function automatic rnd_t round_product(input prod_t p);
        prod_t biased;
        biased = p + prod_t'(1 << (CoefFrac - 1));
        return rnd_t'(biased >>> CoefFrac);
    endfunction

    // Clamp a row sum into the 32-bit signed range.
    function automatic coord_t saturate(input sum_t s);
        if (s[SumWidth-1:CoordWidth-1] == '0 || s[SumWidth-1:CoordWidth-1] == '1)
            return coord_t'(s[CoordWidth-1:0]);
        else if (s[SumWidth-1])
            return CoordMin;
        else
            return CoordMax;
    endfunction

    function automatic logic overflows(input sum_t s);
        return !(s[SumWidth-1:CoordWidth-1] == '0 || s[SumWidth-1:CoordWidth-1] == '1);
    endfunction

endpackage

`default_nettype wire

@@ hdl/affine_point_transform_top.sv @@
// ----------------------------------------------------------------------------
// Affine point transform
// Applies a configurable 3x4 affine matrix to a stream of Q24.8 points.
// ----------------------------------------------------------------------------
// The block accepts one point per clock cycle while in_ready is high and
// returns its transformed point. Input register, nine parallel 32x16
// multipliers, product rounding, row summation and saturation each take one
// stage, and the multiplier stage sets the cycle time. Back-pressure on the output stalls the
// pipeline stage by stage, so in_ready stays high as long as any stage has a
// free slot. Configuration writes are always accepted and must only be issued
// while no item is in flight; after reset the matrix is the identity with no
// translation.
`default_nettype none

module affine_point_transform_top
    import apt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [31:0]    in_x,
    input  wire logic signed [31:0]    in_y,
    input  wire logic signed [31:0]    in_z,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         out_x,
    output logic signed [31:0]         out_y,
    output logic signed [31:0]         out_z,
    output logic                       status,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CfgIdxW-1:0]    cfg_index,
    input  wire logic [LinWidth-1:0]   cfg_data
);

    // Configuration registers
    lin_t   linear_reg [NumAxes];
    coord_t offset_reg [NumAxes];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            linear_reg[0] <= Row0LinearReset;
            linear_reg[1] <= Row1LinearReset;
            linear_reg[2] <= Row2LinearReset;
            offset_reg[0] <= '0;
            offset_reg[1] <= '0;
            offset_reg[2] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                RegRow0Linear: linear_reg[0] <= cfg_data;
                RegRow1Linear: linear_reg[1] <= cfg_data;
                RegRow2Linear: linear_reg[2] <= cfg_data;
                RegRow0Offset: offset_reg[0] <= coord_t'(cfg_data[CoordWidth-1:0]);
                RegRow1Offset: offset_reg[1] <= coord_t'(cfg_data[CoordWidth-1:0]);
                RegRow2Offset: offset_reg[2] <= coord_t'(cfg_data[CoordWidth-1:0]);
                default: ;
            endcase
        end
    end

    // Stage valid bits and load enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic ld1, ld2, ld3, ld4, ld5;

    assign ld5 = !v5_reg || out_ready;
    assign ld4 = !v4_reg || ld5;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;

    assign in_ready  = ld1;
    assign out_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
        end
    end

    // Stage payloads
    coord_t coord_reg [NumAxes];
    prod_t  prod_reg  [NumAxes][NumAxes];
    rnd_t   rnd_reg   [NumAxes][NumAxes];
    sum_t   sum_reg   [NumAxes];
    coord_t res_reg   [NumAxes];
    logic   status_reg;

    sum_t   sum_next  [NumAxes];
    logic   status_next;

    always_comb
    begin
        status_next = 1'b0;
        for (int r = 0; r < NumAxes; r++)
        begin
            sum_next[r] = sum_t'(offset_reg[r]) + sum_t'(rnd_reg[r][0])
                        + sum_t'(rnd_reg[r][1]) + sum_t'(rnd_reg[r][2]);
            status_next = status_next | overflows(sum_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            coord_reg[0] <= in_x;
            coord_reg[1] <= in_y;
            coord_reg[2] <= in_z;
        end
        for (int r = 0; r < NumAxes; r++)
        begin
            for (int c = 0; c < NumAxes; c++)
            begin
                if (ld2)
                    prod_reg[r][c] <= prod_t'(coef_t'(linear_reg[r][CoefWidth*c +: CoefWidth]))
                                    * prod_t'(coord_reg[c]);
                if (ld3)
                    rnd_reg[r][c] <= round_product(prod_reg[r][c]);
            end
            if (ld4)
                sum_reg[r] <= sum_next[r];
            if (ld5)
                res_reg[r] <= saturate(sum_reg[r]);
        end
        if (ld5)
            status_reg <= status_next;
    end

    assign out_x  = res_reg[0];
    assign out_y  = res_reg[1];
    assign out_z  = res_reg[2];
    assign status = status_reg;

    // A raised status means at least one row sits at a 32-bit limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |->
            (out_x == CoordMax || out_x == CoordMin || out_y == CoordMax ||
             out_y == CoordMin || out_z == CoordMax || out_z == CoordMin))
        else $error("status raised without a saturated row");

    // Input back-pressure only happens when every stage is full and the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_valid && !out_ready))
        else $error("input stalled with a free pipeline slot");

    // A summed row that moves on must appear at the output on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && ld5) |=> out_valid)
        else $error("item lost between summation and output");

endmodule

`default_nettype wire
